>>> rtl/markov_word_graph_engine_macros.svh
// Assertion macros used by the word graph engine RTL.
`ifndef MARKOV_WORD_GRAPH_ENGINE_MACROS_SVH
`define MARKOV_WORD_GRAPH_ENGINE_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define MWG_ASSERT(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Checks that a condition in one cycle leads to another in the next cycle.
`define MWG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/mwg_pkg.sv
// Package with codes, widths and defaults of the word graph engine.
`timescale 1ns / 1ps
`default_nettype none
package mwg_pkg;
	localparam int NODE_CAPACITY_DEF = 1024;
	localparam int SUCC_CAPACITY_DEF = 64;
	localparam int HASH_WIDTH_DEF    = 32;
	localparam int HASH_SEED         = 7890;
	localparam int ACTION_W          = 2;
	localparam int BYTE_W            = 8;
	localparam int RAND_W            = 31;
	localparam int NODE_IDX_W        = 10;
	localparam int STATUS_W          = 3;
	localparam int MOD_CNT_W         = $clog2(RAND_W + 1);

	typedef enum logic [ACTION_W-1:0] {
		ACT_BYTE  = 2'd0,
		ACT_LEARN = 2'd1,
		ACT_SEED  = 2'd2,
		ACT_WALK  = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_FOUND   = 3'd0,
		ST_CREATED = 3'd1,
		ST_FULL    = 3'd2,
		ST_EMITTED = 3'd3,
		ST_JUMPED  = 3'd4,
		ST_EMPTY   = 3'd5
	} status_t;
endpackage
`default_nettype wire

>>> rtl/mwg_mod_unit.sv
// Bit-serial restoring remainder unit, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module mwg_mod_unit #(
	parameter int DW = 11
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [mwg_pkg::RAND_W-1:0]    dividend,
	input  wire logic [DW-1:0]                 divisor,
	output logic                               done,
	output logic [DW-1:0]                      remainder
);
	localparam int RW = mwg_pkg::RAND_W;
	localparam int CNW = mwg_pkg::MOD_CNT_W;

	logic [DW-1:0]  rem_q;
	logic [DW-1:0]  div_q;
	logic [RW-1:0]  dvd_q;
	logic [CNW-1:0] cnt_q;
	logic           run_q;
	logic           done_q;
	logic [DW:0]    trial;
	logic [DW:0]    diff;
	logic           fits;

	// Shift in the next dividend bit and try to subtract the divisor.
	always_comb begin
		trial = {rem_q, dvd_q[RW-1]};
		diff  = trial - {1'b0, div_q};
		fits  = trial >= {1'b0, div_q};
	end

	// One restoring step per cycle for every dividend bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			div_q  <= '0;
			dvd_q  <= '0;
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			rem_q  <= '0;
			div_q  <= divisor;
			dvd_q  <= dividend;
			cnt_q  <= CNW'(RW);
			run_q  <= 1'b1;
			done_q <= 1'b0;
		end else if (run_q) begin
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
			dvd_q <= {dvd_q[RW-2:0], 1'b0};
			cnt_q <= cnt_q - CNW'(1);
			if (cnt_q == CNW'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

>>> rtl/markov_word_graph_engine.sv
// Word byte beat: updates the word hash, no result. End of word: one node table entry per cycle,
// then, for a learn after a different learned word, a count read and a successor scan, then the
// result goes into the output register once it is not stalled. Walk step: a count read, the
// 31-step bit-serial remainder unit, and for a successor a list read. Items are taken one at a
// time. Reset is asynchronous and clears control state and counters; tables are not cleared,
// as only written entries are read.
`timescale 1ns / 1ps
`default_nettype none
`include "markov_word_graph_engine_macros.svh"
module markov_word_graph_engine #(
	parameter int NODE_CAPACITY      = mwg_pkg::NODE_CAPACITY_DEF,
	parameter int SUCCESSOR_CAPACITY = mwg_pkg::SUCC_CAPACITY_DEF,
	parameter int HASH_WIDTH         = mwg_pkg::HASH_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [mwg_pkg::ACTION_W-1:0]    action,
	input  wire logic [mwg_pkg::BYTE_W-1:0]      byte_req,
	input  wire logic [mwg_pkg::RAND_W-1:0]      random_value,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [mwg_pkg::NODE_IDX_W-1:0]       node_index,
	output logic [mwg_pkg::STATUS_W-1:0]         status
);
	localparam int HW  = HASH_WIDTH;
	localparam int NIW = $clog2(NODE_CAPACITY);
	localparam int CW  = $clog2(NODE_CAPACITY + 1);
	localparam int SCW = $clog2(SUCCESSOR_CAPACITY + 1);
	localparam int SIW = (SUCCESSOR_CAPACITY > 1) ? $clog2(SUCCESSOR_CAPACITY) : 1;
	localparam int LD  = NODE_CAPACITY * SUCCESSOR_CAPACITY;
	localparam int LAW = (LD > 1) ? $clog2(LD) : 1;
	localparam int DW  = (CW > SCW) ? CW : SCW;
	localparam int OIW = mwg_pkg::NODE_IDX_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SRCH,
		S_LCNT,
		S_LCW,
		S_LSRCH,
		S_WCNT,
		S_WCW,
		S_WDIV,
		S_WLR,
		S_WLD,
		S_EMIT
	} state_t;

	state_t                 state_q;
	logic [HW-1:0]          hash_q;
	logic                   has_bytes_q;
	logic [HW-1:0]          key_q;
	logic [CW-1:0]          count_q;
	logic [NIW-1:0]         prev_q;
	logic                   prev_valid_q;
	logic [NIW-1:0]         walk_pos_q;
	mwg_pkg::action_t       act_q;
	logic [mwg_pkg::RAND_W-1:0] rnd_q;
	logic [CW-1:0]          i_q;
	logic                   chk_s1;
	logic [NIW-1:0]         idx_s1;
	logic [NIW-1:0]         from_q;
	logic [NIW-1:0]         to_q;
	logic [SCW-1:0]         n_q;
	logic [SCW-1:0]         j_q;
	logic                   lchk_s1;
	logic                   jump_q;
	logic [NIW-1:0]         node_q;
	mwg_pkg::status_t       stat_q;
	logic                   out_valid_q;
	logic [NIW-1:0]         out_node_q;
	mwg_pkg::status_t       out_stat_q;

	// Table memories and their registered read data.
	logic [HW-1:0]          hash_mem [NODE_CAPACITY];
	logic [SCW-1:0]         cnt_mem [NODE_CAPACITY];
	logic [NIW-1:0]         list_mem [LD];
	logic [HW-1:0]          hash_rd;
	logic [SCW-1:0]         cnt_rd;
	logic [NIW-1:0]         list_rd;

	logic                   accept;
	logic                   emit_go;
	logic                   match;
	logic                   scan_end;
	logic                   table_full;
	logic                   create;
	logic [NIW-1:0]         word_node;
	logic                   lmatch;
	logic                   lscan_end;
	logic                   link_add;
	logic [NIW-1:0]         cnt_raddr;
	logic [LAW-1:0]         list_raddr;
	logic [LAW-1:0]         list_waddr;
	logic                   mod_start;
	logic [DW-1:0]          mod_divisor;
	logic                   mod_done;
	logic [DW-1:0]          mod_rem;

	// Flat address of one slot in a node's successor list.
	function automatic logic [LAW-1:0] list_addr(input logic [NIW-1:0] node,
			input logic [SIW-1:0] slot);
		list_addr = LAW'(node) * LAW'(SUCCESSOR_CAPACITY) + LAW'(slot);
	endfunction

	assign accept  = in_valid && !in_stall;
	assign emit_go = (state_q == S_EMIT) && (!out_valid_q || !out_stall);

	// Node table scan: compare the entry read last cycle with the key.
	always_comb begin
		match      = chk_s1 && (hash_rd == key_q);
		scan_end   = !match && (i_q >= count_q);
		table_full = count_q == CW'(NODE_CAPACITY);
		create     = (state_q == S_SRCH) && scan_end && !table_full;
		word_node  = match ? idx_s1 : count_q[NIW-1:0];
	end

	// Successor scan: same scheme over the previous node's list.
	always_comb begin
		lmatch    = lchk_s1 && (list_rd == to_q);
		lscan_end = !lmatch && (j_q >= n_q);
		link_add  = (state_q == S_LSRCH) && lscan_end && (n_q < SCW'(SUCCESSOR_CAPACITY));
	end

	// Read address selection for the count and list memories.
	always_comb begin
		cnt_raddr  = (state_q == S_LCNT) ? from_q : walk_pos_q;
		list_raddr = (state_q == S_LSRCH) ? list_addr(from_q, SIW'(j_q))
			: list_addr(walk_pos_q, SIW'(mod_rem));
		list_waddr = list_addr(from_q, SIW'(n_q));
	end

	// Divider start and operand selection for the walk step.
	always_comb begin
		mod_start   = state_q == S_WCW;
		mod_divisor = (cnt_rd != '0) ? DW'(cnt_rd) : DW'(count_q);
	end

	mwg_mod_unit #(
		.DW(DW)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (rnd_q),
		.divisor   (mod_divisor),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	// Memory writes and registered reads.
	always_ff @(posedge clk) begin
		if (create) begin
			hash_mem[count_q[NIW-1:0]] <= key_q;
		end
		if (create) begin
			cnt_mem[count_q[NIW-1:0]] <= '0;
		end else if (link_add) begin
			cnt_mem[from_q] <= n_q + SCW'(1);
		end
		if (link_add) begin
			list_mem[list_waddr] <= to_q;
		end
		hash_rd <= hash_mem[i_q[NIW-1:0]];
		cnt_rd  <= cnt_mem[cnt_raddr];
		list_rd <= list_mem[list_raddr];
	end

	// Sequencer with its registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			hash_q       <= HW'(mwg_pkg::HASH_SEED);
			has_bytes_q  <= 1'b0;
			key_q        <= '0;
			count_q      <= '0;
			prev_q       <= '0;
			prev_valid_q <= 1'b0;
			walk_pos_q   <= '0;
			act_q        <= mwg_pkg::ACT_BYTE;
			rnd_q        <= '0;
			i_q          <= '0;
			chk_s1       <= 1'b0;
			idx_s1       <= '0;
			from_q       <= '0;
			to_q         <= '0;
			n_q          <= '0;
			j_q          <= '0;
			lchk_s1      <= 1'b0;
			jump_q       <= 1'b0;
			node_q       <= '0;
			stat_q       <= mwg_pkg::ST_EMPTY;
			out_valid_q  <= 1'b0;
			out_node_q   <= '0;
			out_stat_q   <= mwg_pkg::ST_EMPTY;
		end else begin
			// Output register: a beat leaves when it is not stalled.
			if (emit_go) begin
				out_valid_q <= 1'b1;
				out_node_q  <= node_q;
				out_stat_q  <= stat_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (mwg_pkg::action_t'(action))
							mwg_pkg::ACT_BYTE: begin
								hash_q      <= (hash_q << 5) + hash_q + HW'(byte_req);
								has_bytes_q <= 1'b1;
							end
							mwg_pkg::ACT_WALK: begin
								rnd_q <= random_value;
								if (count_q == '0) begin
									node_q  <= '0;
									stat_q  <= mwg_pkg::ST_EMPTY;
									state_q <= S_EMIT;
								end else begin
									state_q <= S_WCNT;
								end
							end
							default: begin
								act_q       <= mwg_pkg::action_t'(action);
								hash_q      <= HW'(mwg_pkg::HASH_SEED);
								has_bytes_q <= 1'b0;
								key_q       <= hash_q;
								i_q         <= '0;
								chk_s1      <= 1'b0;
								if (!has_bytes_q) begin
									node_q  <= '0;
									stat_q  <= mwg_pkg::ST_EMPTY;
									state_q <= S_EMIT;
								end else begin
									state_q <= S_SRCH;
								end
							end
						endcase
					end
				end

				S_SRCH: begin
					if (match || scan_end) begin
						chk_s1 <= 1'b0;
						if (!match && table_full) begin
							node_q  <= '0;
							stat_q  <= mwg_pkg::ST_FULL;
							state_q <= S_EMIT;
						end else begin
							node_q <= word_node;
							stat_q <= match ? mwg_pkg::ST_FOUND : mwg_pkg::ST_CREATED;
							if (!match) begin
								count_q <= count_q + CW'(1);
							end
							if (act_q == mwg_pkg::ACT_LEARN) begin
								prev_q       <= word_node;
								prev_valid_q <= 1'b1;
								from_q       <= prev_q;
								to_q         <= word_node;
								if (prev_valid_q && (prev_q != word_node)) begin
									state_q <= S_LCNT;
								end else begin
									state_q <= S_EMIT;
								end
							end else begin
								walk_pos_q <= word_node;
								state_q    <= S_EMIT;
							end
						end
					end else if (i_q < count_q) begin
						chk_s1 <= 1'b1;
						idx_s1 <= i_q[NIW-1:0];
						i_q    <= i_q + CW'(1);
					end else begin
						chk_s1 <= 1'b0;
					end
				end

				S_LCNT: begin
					state_q <= S_LCW;
				end

				S_LCW: begin
					n_q     <= cnt_rd;
					j_q     <= '0;
					lchk_s1 <= 1'b0;
					state_q <= S_LSRCH;
				end

				S_LSRCH: begin
					if (lmatch || lscan_end) begin
						lchk_s1 <= 1'b0;
						state_q <= S_EMIT;
					end else if (j_q < n_q) begin
						lchk_s1 <= 1'b1;
						j_q     <= j_q + SCW'(1);
					end else begin
						lchk_s1 <= 1'b0;
					end
				end

				S_WCNT: begin
					state_q <= S_WCW;
				end

				S_WCW: begin
					jump_q  <= cnt_rd == '0;
					state_q <= S_WDIV;
				end

				S_WDIV: begin
					if (mod_done) begin
						if (jump_q) begin
							node_q     <= NIW'(mod_rem);
							walk_pos_q <= NIW'(mod_rem);
							stat_q     <= mwg_pkg::ST_JUMPED;
							state_q    <= S_EMIT;
						end else begin
							state_q <= S_WLR;
						end
					end
				end

				S_WLR: begin
					state_q <= S_WLD;
				end

				S_WLD: begin
					node_q     <= list_rd;
					walk_pos_q <= list_rd;
					stat_q     <= mwg_pkg::ST_EMITTED;
					state_q    <= S_EMIT;
				end

				S_EMIT: begin
					if (emit_go) begin
						state_q <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall   = state_q != S_IDLE;
	assign out_valid  = out_valid_q;
	assign node_index = OIW'(out_node_q);
	assign status     = out_stat_q;

	// The node count never passes the table size.
	`MWG_ASSERT(a_count_cap, count_q <= CW'(NODE_CAPACITY), "node count above capacity")
	// The walk position always names an existing node.
	`MWG_ASSERT(a_walk_range, (count_q == '0) || (CW'(walk_pos_q) < count_q), "walk out of range")
	// The remainder unit only finishes while the walk waits for it.
	`MWG_ASSERT(a_mod_state, !mod_done || (state_q == S_WDIV), "remainder done outside walk step")
	// Any beat other than a word byte makes the block busy.
	`MWG_ASSERT_NEXT(a_busy_after, accept && (action != mwg_pkg::ACT_BYTE), in_stall, "idle after item")
endmodule
`default_nettype wire

>>> tb/sv/tb_markov_word_graph_engine.sv
// Self-checking testbench for the word Markov chain graph engine.
`timescale 1ns / 1ps
`default_nettype none
module tb_markov_word_graph_engine;
	localparam int NODES       = mwg_pkg::NODE_CAPACITY_DEF;
	localparam int SUCCS       = mwg_pkg::SUCC_CAPACITY_DEF;
	localparam int RW          = mwg_pkg::RAND_W;
	localparam int NW          = mwg_pkg::NODE_IDX_W;
	localparam int CYCLE_LIMIT = 4000000;

	typedef struct {
		mwg_pkg::action_t act;
		bit [7:0]         chr;
		bit [RW-1:0]      rnd;
	} beat_t;

	typedef struct {
		bit [NW-1:0]      node;
		mwg_pkg::status_t st;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid;
	logic in_stall;
	logic [mwg_pkg::ACTION_W-1:0] action;
	logic [mwg_pkg::BYTE_W-1:0] byte_req;
	logic [RW-1:0] random_value;
	logic out_valid;
	logic out_stall;
	logic [NW-1:0] node_index;
	logic [mwg_pkg::STATUS_W-1:0] status;

	markov_word_graph_engine u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .byte_req(byte_req), .random_value(random_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.node_index(node_index), .status(status)
	);

	always #6 clk = ~clk;

	// Mirror of the engine state.
	bit [31:0] word_hash;
	bit        word_open;
	bit [31:0] hash_table [NODES];
	int unsigned node_total;
	int unsigned fanout [NODES];
	int unsigned links [NODES][SUCCS];
	int unsigned prior_node;
	bit        prior_ok;
	int unsigned walk_at;

	beat_t   pending [$];
	answer_t awaited [$];
	int unsigned cycles;
	int unsigned failures;
	int unsigned beats_in;
	int unsigned answers_out;
	int unsigned per_status [8];
	int unsigned hold_left;

	// Word lookup with append; returns the status and the node index.
	task automatic find_or_add(output mwg_pkg::status_t st, output int unsigned idx);
		idx = 0;
		for (int unsigned i = 0; i < node_total; i++) begin
			if (hash_table[i] == word_hash) begin
				idx = i;
				st = mwg_pkg::ST_FOUND;
				return;
			end
		end
		if (node_total >= NODES) begin
			st = mwg_pkg::ST_FULL;
			return;
		end
		hash_table[node_total] = word_hash;
		fanout[node_total] = 0;
		idx = node_total;
		node_total++;
		st = mwg_pkg::ST_CREATED;
	endtask

	// Advances the mirror by one accepted beat and queues any answer.
	task automatic graph_step(beat_t b);
		mwg_pkg::status_t st;
		int unsigned idx;
		int unsigned n;
		bit dup;
		idx = 0;
		if (b.act == mwg_pkg::ACT_BYTE) begin
			word_hash = word_hash * 33 + b.chr;
			word_open = 1'b1;
			return;
		end
		if (b.act == mwg_pkg::ACT_WALK) begin
			if (node_total == 0) begin
				st = mwg_pkg::ST_EMPTY;
			end else begin
				n = fanout[walk_at];
				if (n > 0) begin
					idx = links[walk_at][b.rnd % n];
					st = mwg_pkg::ST_EMITTED;
				end else begin
					idx = b.rnd % node_total;
					st = mwg_pkg::ST_JUMPED;
				end
				walk_at = idx;
			end
		end else begin
			if (!word_open) begin
				st = mwg_pkg::ST_EMPTY;
			end else begin
				find_or_add(st, idx);
				if (st != mwg_pkg::ST_FULL) begin
					if (b.act == mwg_pkg::ACT_LEARN) begin
						if (prior_ok && prior_node != idx) begin
							n = fanout[prior_node];
							dup = 1'b0;
							for (int unsigned i = 0; i < n; i++)
								if (links[prior_node][i] == idx)
									dup = 1'b1;
							if (!dup && n < SUCCS) begin
								links[prior_node][n] = idx;
								fanout[prior_node] = n + 1;
							end
						end
						prior_node = idx;
						prior_ok = 1'b1;
					end else begin
						walk_at = idx;
					end
				end
			end
			word_hash = mwg_pkg::HASH_SEED;
			word_open = 1'b0;
		end
		awaited.push_back('{node: idx[NW-1:0], st: st});
	endtask

	// Mostly short gaps, some long ones, and stretches with none.
	function automatic int unsigned pick_gap(int unsigned phase);
		int unsigned p;
		if ((phase / 80) % 3 == 0)
			return 0;
		p = $urandom_range(99);
		if (p < 60)
			return 0;
		if (p < 95)
			return $urandom_range(3, 1);
		return $urandom_range(60, 15);
	endfunction

	// Stimulus helpers.
	function automatic beat_t mk(mwg_pkg::action_t a, bit [7:0] c, bit [RW-1:0] r);
		beat_t b;
		b.act = a;
		b.chr = c;
		b.rnd = r;
		return b;
	endfunction

	task automatic push_word(bit [7:0] w [$], mwg_pkg::action_t ending);
		foreach (w[i])
			pending.push_back(mk(mwg_pkg::ACT_BYTE, w[i], RW'($urandom())));
		pending.push_back(mk(ending, 8'($urandom()), RW'($urandom())));
	endtask

	task automatic push_walk();
		pending.push_back(mk(mwg_pkg::ACT_WALK, 8'($urandom()), RW'($urandom())));
	endtask

	// Sender: presents queued beats and updates the mirror on acceptance.
	always @(posedge clk or negedge arst_n) begin
		int unsigned gap;
		bit nxt;
		beat_t b;
		if (!arst_n) begin
			in_valid <= 1'b0;
			action <= mwg_pkg::ACT_BYTE;
			byte_req <= '0;
			random_value <= '0;
			gap = 0;
		end else begin
			nxt = in_valid;
			if (in_valid && !in_stall) begin
				graph_step(mk(mwg_pkg::action_t'(action), byte_req, random_value));
				beats_in++;
				nxt = 1'b0;
			end
			if (!nxt) begin
				if (gap > 0) begin
					gap--;
				end else if (pending.size() > 0) begin
					b = pending.pop_front();
					action <= b.act;
					byte_req <= b.chr;
					random_value <= b.rnd;
					nxt = 1'b1;
					gap = pick_gap(beats_in);
				end
			end
			in_valid <= nxt;
		end
	end

	// One long receiver hold-off while the sender keeps offering beats.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (cycles == 6000)
			hold_left <= 3000;
		else if (hold_left > 0)
			hold_left <= hold_left - 1;
	end

	// Receiver: random stalls and field-by-field comparison.
	always @(posedge clk or negedge arst_n) begin
		int unsigned stall_run;
		int unsigned p;
		answer_t a;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_run = 0;
		end else begin
			if (out_valid && !out_stall) begin
				answers_out++;
				per_status[status]++;
				if (awaited.size() == 0) begin
					$error("unexpected result: node_index %0d status %0d", node_index, status);
					failures++;
				end else begin
					a = awaited.pop_front();
					if (node_index !== a.node) begin
						$error("node_index: expected %0d, actual %0d", a.node, node_index);
						failures++;
					end
					if (status !== a.st) begin
						$error("status: expected %0d, actual %0d", a.st, status);
						failures++;
					end
				end
			end
			if (stall_run > 0) begin
				stall_run--;
			end else if ((cycles / 700) % 3 != 0) begin
				p = $urandom_range(99);
				if (p < 25)
					stall_run = $urandom_range(3, 1);
				else if (p < 28)
					stall_run = $urandom_range(80, 20);
			end
			out_stall <= (hold_left > 0) || (stall_run > 0);
		end
	end

	// Cycle count and timeout.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Builds the stimulus, then waits for the last answer.
	initial begin
		bit [7:0] w [$];
		bit [7:0] vocab [20][$];
		bit [7:0] hub [$];
		int unsigned p;
		int unsigned total_beats;
		failures = 0;
		beats_in = 0;
		answers_out = 0;
		foreach (per_status[i])
			per_status[i] = 0;
		word_hash = mwg_pkg::HASH_SEED;
		word_open = 1'b0;
		node_total = 0;
		prior_node = 0;
		prior_ok = 1'b0;
		walk_at = 0;

		// Directed: empty tables, empty words, byte extremes, self-links, walks.
		push_walk();
		pending.push_back(mk(mwg_pkg::ACT_LEARN, 8'h00, '0));
		pending.push_back(mk(mwg_pkg::ACT_SEED, 8'hFF, '1));
		w = '{8'h00};
		push_word(w, mwg_pkg::ACT_LEARN);
		w = '{8'hFF, 8'hFF};
		push_word(w, mwg_pkg::ACT_LEARN);
		push_word(w, mwg_pkg::ACT_LEARN);
		w = '{8'h00};
		push_word(w, mwg_pkg::ACT_LEARN);
		pending.push_back(mk(mwg_pkg::ACT_WALK, 8'h00, '0));
		pending.push_back(mk(mwg_pkg::ACT_WALK, 8'hFF, '1));
		w = '{8'h41, 8'h80};
		push_word(w, mwg_pkg::ACT_SEED);
		pending.push_back(mk(mwg_pkg::ACT_WALK, 8'h00, 31'h7FFF_FFFF));
		pending.push_back(mk(mwg_pkg::ACT_SEED, 8'h00, '0));

		// Fan-out from one hub word past the successor capacity.
		hub = '{8'h68};
		for (int i = 0; i < SUCCS + 4; i++) begin
			push_word(hub, mwg_pkg::ACT_LEARN);
			w = '{8'h80 + i[7:0]};
			push_word(w, mwg_pkg::ACT_LEARN);
		end
		push_word(hub, mwg_pkg::ACT_SEED);
		repeat (4)
			push_walk();

		// Random sentences over a small vocabulary, with noise.
		foreach (vocab[i]) begin
			p = $urandom_range(4, 1);
			repeat (p)
				vocab[i].push_back(8'($urandom()));
		end
		while (pending.size() < 540) begin
			p = $urandom_range(99);
			if (p < 60) begin
				push_word(vocab[$urandom_range(19)], mwg_pkg::ACT_LEARN);
			end else if (p < 68) begin
				push_word(vocab[$urandom_range(19)], mwg_pkg::ACT_SEED);
			end else if (p < 88) begin
				push_walk();
			end else if (p < 95) begin
				w.delete();
				repeat ($urandom_range(5, 1))
					w.push_back(8'($urandom()));
				push_word(w, p[0] ? mwg_pkg::ACT_LEARN : mwg_pkg::ACT_SEED);
			end else begin
				pending.push_back(mk(p[0] ? mwg_pkg::ACT_LEARN : mwg_pkg::ACT_SEED,
					8'($urandom()), RW'($urandom())));
			end
		end
		total_beats = pending.size();

		wait (arst_n);
		wait (beats_in == total_beats && awaited.size() == 0);
		repeat (200) @(posedge clk);
		$display("Covered %0d input beats and %0d results, node table filled to %0d.",
			beats_in, answers_out, node_total);
		$display("Results by status: found %0d, created %0d, full %0d, emitted %0d, jumped %0d, empty %0d.",
			per_status[0], per_status[1], per_status[2], per_status[3], per_status[4],
			per_status[5]);
		if (failures == 0 && awaited.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Reset held low at the start, then released.
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end
endmodule
`default_nettype wire
